FILE: design/tks_pkg.sv
`timescale 1ns / 1ps
package tks_pkg;

  localparam int VOCAB_MAX       = 2048;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int IDX_W   = $clog2(VOCAB_MAX);
  localparam int CNT_W   = $clog2(VOCAB_MAX + 1);
  localparam int EXP_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int LOGIT_W = 16;
  localparam int DRAW_W  = 16;
  localparam int ITEMP_W = 16;
  localparam int TOPK_W  = 12;
  localparam int TOPP_W  = 17;
  localparam int CODE_W  = 11;
  localparam int W_W     = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  // rank key: biased logit above inverted index, larger key ranks first
  localparam int KEY_W  = LOGIT_W + IDX_W;
  // sums of weights over the whole vector
  localparam int SUM_W  = IDX_W + W_W;
  localparam int PT_W   = TOPP_W + SUM_W;
  localparam int TGT_W  = DRAW_W + SUM_W;
  localparam int FRAC_W = 16;
  localparam int DIFF_W = LOGIT_W + 1;
  localparam int PROD_W = DIFF_W + ITEMP_W;
  localparam int GAP_SHIFT = 10;
  localparam int GAP_W  = PROD_W - GAP_SHIFT;

  localparam logic [TOPP_W-1:0] ONE_Q16 = TOPP_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOPK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOPP     = 2'd3;

  // exp(-i/64) in Q1.16, built from a Q32.32 running product
  function automatic logic [EXP_TABLE_DEPTH-1:0][W_W-1:0] build_exp_table();
    logic [EXP_TABLE_DEPTH-1:0][W_W-1:0] t;
    logic [63:0]  a;
    logic [127:0] m;
    logic [63:0]  e;
    a = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      e = (a + 64'd32768) >> 16;
      t[i] = e[W_W-1:0];
      m = ({64'd0, a} * 128'd4228380000) + (128'd1 << 31);
      a = m[95:32];
    end
    return t;
  endfunction

  localparam logic [EXP_TABLE_DEPTH-1:0][W_W-1:0] EXP_TABLE = build_exp_table();

endpackage

FILE: design/tks_if.sv
`timescale 1ns / 1ps
interface tks_in_if;
  import tks_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LOGIT_W-1:0] logit;
  logic [DRAW_W-1:0]         draw;
  logic                      last_logit;
  modport source(output valid, logit, draw, last_logit, input ready);
  modport sink(input valid, logit, draw, last_logit, output ready);
endinterface

interface tks_out_if;
  import tks_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  modport source(output valid, code, input ready);
  modport sink(input valid, code, output ready);
endinterface

FILE: design/tks_ram.sv
`timescale 1ns / 1ps
module tks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/tks_weight.sv
`timescale 1ns / 1ps
module tks_weight (
  input  logic                         clk,
  input  logic [tks_pkg::DIFF_W-1:0]   diff,
  input  logic [tks_pkg::ITEMP_W-1:0]  itemp,
  output logic [tks_pkg::W_W-1:0]      weight
);
  import tks_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [GAP_W-1:0]  gap;

  // scaled gap registered, table lookup on the next cycle
  always_ff @(posedge clk) begin
    prod <= PROD_W'(diff) * PROD_W'(itemp);
  end

  assign gap    = prod[PROD_W-1:GAP_SHIFT];
  assign weight = (gap < GAP_W'(EXP_TABLE_DEPTH)) ? EXP_TABLE[gap[EXP_W-1:0]] : '0;
endmodule

FILE: design/top_k_top_p_sampler.sv
`timescale 1ns / 1ps
// Top-k / top-p sampler. Logits (signed Q8.8) stream in one item per cycle into
// a logit memory; the item marked last also carries the Q0.16 draw, and one
// code comes out per vector. With sampling off or inverse temperature zero the
// block makes one scan of the memory and returns the first maximum. Otherwise
// it builds the rank order by repeated selection scans over the logit memory
// read port, one scan per kept rank (keep = top_k or n, n being the vector
// length). Then come a weight walk over the kept ranks, a top-p walk and a
// draw walk. The input is held off while a vector is being worked on; the
// finished code sits in an output register so the next vector may load while
// it waits to be taken. Sampling mode and top-k are sampled when the last item
// arrives. Configuration must stay still until the code is out. No clearing
// pass is needed after reset.
module top_k_top_p_sampler (
  input  logic                          clk,
  input  logic                          rst,
  tks_in_if.sink                        logits,
  tks_out_if.source                     result,
  input  logic                          cfg_wr_en,
  input  logic [tks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tks_pkg::CFG_W-1:0]     cfg_data
);
  import tks_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_W0   = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_W3   = 4'd5;
  localparam logic [3:0] S_PT   = 4'd6;
  localparam logic [3:0] S_B0   = 4'd7;
  localparam logic [3:0] S_B1   = 4'd8;
  localparam logic [3:0] S_TG   = 4'd9;
  localparam logic [3:0] S_C0   = 4'd10;
  localparam logic [3:0] S_C1   = 4'd11;
  localparam logic [3:0] S_C2   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // configuration
  logic                sampling_enabled;
  logic [ITEMP_W-1:0]  inverse_temperature;
  logic [TOPK_W-1:0]   top_k_limit;
  logic [TOPP_W-1:0]   top_p_mass;

  // control
  logic [3:0]          state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    keep;
  logic [CNT_W-1:0]    r;
  logic [CNT_W-1:0]    scan_addr;
  logic                argmax_mode;
  logic                d_vld;
  logic                best_vld;
  logic                out_valid;

  // datapath
  logic [DRAW_W-1:0]   held_draw;
  logic [IDX_W-1:0]    d_idx;
  logic [KEY_W-1:0]    best_key;
  logic [KEY_W-1:0]    bound;
  logic [LOGIT_W-1:0]  top_logit;
  logic [SUM_W-1:0]    total;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    retained;
  logic [PT_W-1:0]     pt;
  logic [TGT_W-1:0]    target;
  logic [IDX_W-1:0]    surv_last;
  logic [CODE_W-1:0]   res_code;
  logic [CODE_W-1:0]   out_code;

  // memory ports
  logic                logit_we;
  logic [IDX_W-1:0]    logit_raddr;
  logic [LOGIT_W-1:0]  logit_rd;
  logic                rank_we;
  logic [IDX_W-1:0]    rank_raddr;
  logic [IDX_W-1:0]    rank_rd;
  logic                wt_we;
  logic [IDX_W-1:0]    wt_raddr;
  logic [W_W-1:0]      wt_rd;

  logic                in_fire;
  logic                scan_issue;
  logic                scan_done;
  logic [KEY_W-1:0]    cand_key;
  logic                cand_ok;
  logic [IDX_W-1:0]    best_idx;
  logic [CNT_W-1:0]    count_new;
  logic [TOPP_W-1:0]   p_clamp;
  logic [DIFF_W-1:0]   diff;
  logic [W_W-1:0]      weight;
  logic [SUM_W-1:0]    sum;
  logic                r_last;

  assign in_fire    = logits.valid && logits.ready;
  assign logits.ready = (state == S_LOAD);
  assign result.valid = out_valid;
  assign result.code  = out_code;

  assign count_new  = (count < CNT_W'(VOCAB_MAX)) ? count + 1'b1 : count;
  assign scan_issue = (scan_addr < count);
  assign scan_done  = !scan_issue && !d_vld;
  assign cand_key   = {~logit_rd[LOGIT_W-1], logit_rd[LOGIT_W-2:0], ~d_idx};
  assign cand_ok    = ((r == '0) || (cand_key < bound)) &&
                      (!best_vld || (cand_key > best_key));
  assign best_idx   = ~best_key[IDX_W-1:0];
  assign p_clamp    = (top_p_mass > ONE_Q16) ? ONE_Q16 : top_p_mass;
  assign diff       = {top_logit[LOGIT_W-1], top_logit} - {logit_rd[LOGIT_W-1], logit_rd};
  assign sum        = acc + SUM_W'(wt_rd);
  assign r_last     = (r + 1'b1 == keep);

  // memory address selection
  assign logit_we    = in_fire && (count < CNT_W'(VOCAB_MAX));
  assign logit_raddr = (state == S_W1) ? rank_rd : scan_addr[IDX_W-1:0];
  assign rank_we     = (state == S_SCAN) && scan_done && !argmax_mode;
  assign rank_raddr  = r[IDX_W-1:0];
  assign wt_we       = (state == S_W3);
  assign wt_raddr    = r[IDX_W-1:0];

  tks_ram #(.WIDTH(LOGIT_W), .DEPTH(VOCAB_MAX)) u_logit_ram (
    .clk   (clk),
    .we    (logit_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (logits.logit),
    .raddr (logit_raddr),
    .rdata (logit_rd)
  );

  // rank order, index of the entry at each rank
  tks_ram #(.WIDTH(IDX_W), .DEPTH(VOCAB_MAX)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (r[IDX_W-1:0]),
    .wdata (best_idx),
    .raddr (rank_raddr),
    .rdata (rank_rd)
  );

  // weights kept by rank
  tks_ram #(.WIDTH(W_W), .DEPTH(VOCAB_MAX)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (r[IDX_W-1:0]),
    .wdata (weight),
    .raddr (wt_raddr),
    .rdata (wt_rd)
  );

  tks_weight u_weight (
    .clk    (clk),
    .diff   (diff),
    .itemp  (inverse_temperature),
    .weight (weight)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_enabled    <= 1'b0;
      inverse_temperature <= ITEMP_W'(256);
      top_k_limit         <= '0;
      top_p_mass          <= ONE_Q16;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLING: sampling_enabled    <= cfg_data[0];
        REG_ITEMP:    inverse_temperature <= cfg_data[ITEMP_W-1:0];
        REG_TOPK:     top_k_limit         <= cfg_data[TOPK_W-1:0];
        REG_TOPP:     top_p_mass          <= cfg_data[TOPP_W-1:0];
      endcase
    end
  end

  // selection scan pipeline: address out, data and index back on the next cycle
  always_ff @(posedge clk) begin
    d_idx <= scan_addr[IDX_W-1:0];
    if (state == S_SCAN && d_vld && cand_ok) begin
      best_key <= cand_key;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      keep      <= '0;
      r         <= '0;
      scan_addr <= '0;
      d_vld     <= 1'b0;
      best_vld  <= 1'b0;
      argmax_mode <= 1'b0;
      out_valid <= 1'b0;
      held_draw <= '0;
    end else begin
      // the hand-off state refills the output register itself
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            count <= count_new;
            if (logits.last_logit) begin
              held_draw   <= logits.draw;
              argmax_mode <= !sampling_enabled || (inverse_temperature == '0);
              keep        <= ((top_k_limit == '0) || (top_k_limit >= count_new)) ?
                             count_new : top_k_limit;
              r           <= '0;
              scan_addr   <= '0;
              d_vld       <= 1'b0;
              best_vld    <= 1'b0;
              state       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          d_vld <= scan_issue;
          if (d_vld && cand_ok) begin
            best_vld <= 1'b1;
          end
          if (scan_done) begin
            if (argmax_mode) begin
              res_code <= CODE_W'(best_idx);
              state    <= S_DONE;
            end else begin
              bound <= best_key;
              if (r == '0) begin
                top_logit <= {~best_key[KEY_W-1], best_key[KEY_W-2:IDX_W]};
              end
              scan_addr <= '0;
              best_vld  <= 1'b0;
              if (r_last) begin
                r     <= '0;
                total <= '0;
                state <= S_W0;
              end else begin
                r <= r + 1'b1;
              end
            end
          end
        end
        S_W0: state <= S_W1;
        S_W1: state <= S_W2;
        S_W2: state <= S_W3;
        S_W3: begin
          total <= total + SUM_W'(weight);
          if (r_last) begin
            state <= S_PT;
          end else begin
            r     <= r + 1'b1;
            state <= S_W0;
          end
        end
        S_PT: begin
          pt    <= PT_W'(p_clamp) * PT_W'(total);
          acc   <= '0;
          r     <= '0;
          state <= S_B0;
        end
        S_B0: state <= S_B1;
        S_B1: begin
          // top-p cut: first rank whose cumulative mass reaches p of total
          if ((PT_W'({sum, FRAC_W'(0)}) >= pt) || r_last) begin
            retained  <= sum;
            surv_last <= r[IDX_W-1:0];
            state     <= S_TG;
          end else begin
            acc   <= sum;
            r     <= r + 1'b1;
            state <= S_B0;
          end
        end
        S_TG: begin
          target <= TGT_W'(held_draw) * TGT_W'(retained);
          acc    <= '0;
          r      <= '0;
          state  <= S_C0;
        end
        S_C0: state <= S_C1;
        S_C1: begin
          // inverse cdf: rank_ram is read at r this cycle
          if ((target < TGT_W'({sum, FRAC_W'(0)})) || (r[IDX_W-1:0] == surv_last)) begin
            state <= S_C2;
          end else begin
            acc   <= sum;
            r     <= r + 1'b1;
            state <= S_C0;
          end
        end
        S_C2: begin
          res_code <= CODE_W'(rank_rd);
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_code  <= res_code;
            count     <= '0;
            state     <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // a code only appears after the hand-off state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result item raised outside hand-off");

  // rank writes stay inside the kept range
  a_rank_in_keep: assert property (@(posedge clk) disable iff (rst)
    rank_we |-> (r < keep))
    else $error("rank write beyond kept entries");

  // weight walk only runs on a nonempty kept list within the loaded vector
  a_keep_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_W0) |-> ((keep != '0) && (keep <= count) && (r < keep)))
    else $error("kept count out of range");

endmodule

FILE: bench/top_k_top_p_sampler_test.sv
`timescale 1ns / 1ps
module top_k_top_p_sampler_test;
  import tks_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 1600;

  // one logit item as it goes on the wire
  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic [DRAW_W-1:0]         draw;
    logic                      last;
  } logit_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SAMPLING;
  logic [CFG_W-1:0]     cfg_data  = '0;

  tks_in_if  logits ();
  tks_out_if result ();

  top_k_top_p_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .logits    (logits.sink),
    .result    (result.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // items waiting to be driven and codes waiting to come out
  logit_item_t       pend_q[$];
  logic [CODE_W-1:0] code_q[$];
  int  items_queued   = 0;
  int  items_accepted = 0;
  int  items_sent     = 0;
  int  fail_count     = 0;
  int  cycles         = 0;
  bit  quiet          = 1'b0;  // no idling on either side in this phase

  // our own view of the configuration
  logic                 m_samp;
  logic [ITEMP_W-1:0]   m_itemp;
  logic [TOPK_W-1:0]    m_topk;
  logic [TOPP_W-1:0]    m_topp;

  // predictor state: loaded vector and scratch for ranking and weights
  logic signed [LOGIT_W-1:0] vec_mem[0:VOCAB_MAX-1];
  int                        vec_count = 0;
  int                        order[0:VOCAB_MAX-1];
  longint unsigned           wgt[0:VOCAB_MAX-1];
  longint unsigned           exp_q16[0:EXP_TABLE_DEPTH-1];

  // scratch for building a vector before it is queued
  logic signed [LOGIT_W-1:0] vbuf[0:VOCAB_MAX+15];

  // exp(-i/64) in Q1.16 via a rounded Q96.32 running product
  initial begin
    logic [127:0] acc;
    acc = 128'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      exp_q16[i] = 64'((acc + 128'd32768) >> 16);
      acc = ((acc * 128'd4228380000) + (128'd1 << 31)) >> 32;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // work out the code for the vector now loaded, using draw as the held draw
  function automatic logic [CODE_W-1:0] pick_code(input logic [DRAW_W-1:0] draw);
    int n, best, keep, survivors, j;
    logic signed [LOGIT_W-1:0] top;
    longint unsigned total, cum, retained, target, acc, p, d, gap;
    n = vec_count;
    // argmax path: first maximum wins
    if (!m_samp || m_itemp == 0) begin
      best = 0;
      for (int i = 1; i < n; i++)
        if (vec_mem[i] > vec_mem[best]) best = i;
      return CODE_W'(best);
    end
    // stable descending rank, lower index first on ties
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && vec_mem[order[j-1]] < vec_mem[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    keep = (m_topk == 0 || m_topk >= n) ? n : int'(m_topk);
    top = vec_mem[order[0]];
    total = 0;
    for (int r = 0; r < keep; r++) begin
      d = longint'(int'(top) - int'(vec_mem[order[r]]));
      gap = (d * longint'(m_itemp)) >> GAP_SHIFT;
      wgt[order[r]] = (gap < EXP_TABLE_DEPTH) ? exp_q16[gap] : 0;
      total += wgt[order[r]];
    end
    // top-p cut, mass above one clamps to one
    p = (m_topp > 65536) ? 65536 : longint'(m_topp);
    survivors = keep;
    cum = 0;
    for (int r = 0; r < keep; r++) begin
      cum += wgt[order[r]];
      if (cum * 65536 >= p * total) begin
        survivors = r + 1;
        break;
      end
    end
    retained = 0;
    for (int r = 0; r < survivors; r++) retained += wgt[order[r]];
    // inverse cdf over the survivors
    target = longint'(draw) * retained;
    acc = 0;
    for (int r = 0; r < survivors; r++) begin
      acc += wgt[order[r]];
      if (target < acc * 65536) return CODE_W'(order[r]);
    end
    return CODE_W'(order[survivors-1]);
  endfunction

  // input side: driver changes signals on the falling edge
  logic in_taken = 1'b0;
  int   in_gap   = 0;

  always @(negedge clk) begin
    logit_item_t it;
    if (rst) begin
      logits.valid <= 1'b0;
    end else if (!logits.valid || in_taken) begin
      if (in_gap > 0) begin
        logits.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pend_q.size() > 0) begin
        it = pend_q.pop_front();
        logits.logit      <= it.logit;
        logits.draw       <= it.draw;
        logits.last_logit <= it.last;
        logits.valid      <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        logits.valid <= 1'b0;
      end
    end
  end

  // accepted items feed the predictor right at the rising edge
  always @(posedge clk) begin
    in_taken <= logits.valid && logits.ready && !rst;
    if (!rst && logits.valid && logits.ready) begin
      items_accepted++;
      // overflow: elements past the vector limit are dropped, count saturates
      if (vec_count < VOCAB_MAX) begin
        vec_mem[vec_count] = logits.logit;
        vec_count++;
      end
      if (logits.last_logit) begin
        code_q = {code_q, pick_code(logits.draw)};
        vec_count = 0;
      end
    end
  end

  // output side: random stalls on ready
  int out_stall = 0;
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (out_stall > 0) begin
      result.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      result.ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // compare each code with the oldest expectation
  always @(posedge clk) begin
    logic [CODE_W-1:0] want;
    if (!rst && result.valid && result.ready) begin
      if (code_q.size() == 0) begin
        $display("%0t: unexpected code, expected none, actual %0d", $time, result.code);
        fail_count++;
      end else begin
        want = code_q.pop_front();
        if (result.code !== want) begin
          $display("%0t: code mismatch, expected %0d, actual %0d",
                   $time, want, result.code);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    case (idx)
      REG_SAMPLING: m_samp  = val[0];
      REG_ITEMP:    m_itemp = ITEMP_W'(val);
      REG_TOPK:     m_topk  = TOPK_W'(val);
      REG_TOPP:     m_topp  = TOPP_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int unsigned samp, input int unsigned itemp,
                            input int unsigned topk, input int unsigned topp);
    write_reg(REG_SAMPLING, samp);
    write_reg(REG_ITEMP, itemp);
    write_reg(REG_TOPK, topk);
    write_reg(REG_TOPP, topp);
  endtask

  // queue the first len entries of vbuf as one vector
  task automatic queue_vector(input int len, input logic [DRAW_W-1:0] draw);
    logit_item_t it;
    for (int i = 0; i < len; i++) begin
      it.logit = vbuf[i];
      it.draw  = (i == len - 1) ? draw : DRAW_W'($urandom);
      it.last  = (i == len - 1);
      pend_q = {pend_q, it};
    end
    items_queued += len;
  endtask

  // wait for every item in and every code out, then let the block settle
  task automatic drain();
    while (items_accepted != items_queued || code_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic directed_vec(input int a, input int b, input int c,
                              input logic [DRAW_W-1:0] draw);
    vbuf[0] = LOGIT_W'(a);
    vbuf[1] = LOGIT_W'(b);
    vbuf[2] = LOGIT_W'(c);
    queue_vector(3, draw);
  endtask

  task automatic random_vector();
    int len, mode, base, v, big;
    big = (!m_samp || m_itemp == 0 || (m_topk != 0 && m_topk <= 4));
    len = $urandom_range(0, 99);
    if (big && len < 2) len = $urandom_range(VOCAB_MAX - 2, VOCAB_MAX + 8);
    else if (len < 10) len = $urandom_range(17, 64);
    else len = $urandom_range(1, 16);
    mode = $urandom_range(0, 2);
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = int'($urandom_range(0, 65535)) - 32768;
        1: v = base - int'($urandom_range(0, 600));
        default: v = base - 64 * int'($urandom_range(0, 3));
      endcase
      if (v < -32768) v = -32768;
      vbuf[i] = LOGIT_W'(v);
    end
    v = $urandom_range(0, 9);
    queue_vector(len, (v == 0) ? 16'd0 : (v == 1) ? 16'hFFFF : DRAW_W'($urandom));
    items_sent += len;
  endtask

  initial begin
    int unsigned s, t, k, p;
    int r;
    logits.valid = 1'b0;
    logits.logit = '0;
    logits.draw = '0;
    logits.last_logit = 1'b0;
    result.ready = 1'b0;
    m_samp = 1'b0;
    m_itemp = ITEMP_W'(256);
    m_topk = '0;
    m_topp = TOPP_W'(65536);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // argmax under reset settings: extremes, ties, single item
    directed_vec(-32768, 32767, 32767, 16'd0);
    directed_vec(-32768, -32768, -32768, 16'hFFFF);
    vbuf[0] = 16'sd5;
    queue_vector(1, 16'h1234);
    // overflow: a larger value past the limit must be ignored
    for (int i = 0; i < VOCAB_MAX + 3; i++) vbuf[i] = (i == 2047) ? 16'sd100 : 16'sd0;
    vbuf[VOCAB_MAX + 1] = 16'sd32767;
    queue_vector(VOCAB_MAX + 3, 16'd0);
    drain();

    // sampling with coldest temperature, full mass, draw extremes
    set_config(1, 65535, 0, 65536);
    directed_vec(0, 1, 2, 16'd0);
    directed_vec(0, 0, 0, 16'hFFFF);
    directed_vec(32767, -32768, 32767, 16'h8000);
    drain();
    // hottest temperature so all entries weigh in, top-k over count
    set_config(1, 1, 2048, 65536);
    directed_vec(100, 90, 80, 16'hFFFF);
    directed_vec(-32768, 32767, 0, 16'hC000);
    drain();
    // top-k of one, top-p zero, top-p above one
    set_config(1, 256, 1, 131071);
    directed_vec(10, 20, 30, 16'hFFFF);
    drain();
    set_config(1, 256, 0, 0);
    directed_vec(10, 30, 30, 16'hFFFF);
    drain();
    set_config(1, 256, 0, 131071);
    directed_vec(0, -64, -128, 16'hFFFF);
    drain();
    // inverse temperature zero forces argmax even with sampling on
    set_config(1, 0, 2, 30000);
    directed_vec(3, 7, 7, 16'h7777);
    drain();

    // random phases with random settings
    while (items_sent < RANDOM_ITEMS) begin
      s = ($urandom_range(0, 9) < 8);
      r = $urandom_range(0, 5);
      t = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 65535 : (r == 3) ? 256 :
          (r == 4) ? $urandom_range(1, 2048) : $urandom_range(0, 65535);
      r = $urandom_range(0, 5);
      k = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2048 : (r == 3) ? 4095 :
          $urandom_range(1, 20);
      r = $urandom_range(0, 4);
      p = (r == 0) ? 0 : (r == 1) ? 65536 : (r == 2) ? 131071 : $urandom_range(0, 65536);
      set_config(s, t, k, p);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (20) random_vector();
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
